// ===== rtl/utrx_pkg.sv =====
`default_nettype none

package utrx_pkg;

    // Width of the receive byte counter.
    localparam int COUNT_WIDTH = 16;

    // Frame layout: start bit, eight data bits, stop bit.
    localparam logic [3:0] FRAME_BITS = 4'd10;
    localparam logic [3:0] DATA_BITS  = 4'd8;

    // Event codes carried on the mode field.
    typedef enum logic [1:0] {
        MODE_TICK  = 2'd0,
        MODE_EDGE  = 2'd1,
        MODE_QUEUE = 2'd2,
        MODE_ARM   = 2'd3
    } mode_t;

    // Transmitter status after one transaction.
    typedef struct packed {
        logic line;
        logic busy;
        logic hold_full;
        logic rejected;
        logic done;
    } tx_status_t;

    // Receiver status after one transaction.
    typedef struct packed {
        logic [7:0] byte_data;
        logic       byte_valid;
        logic       done;
        logic       stop_error;
        logic       busy;
    } rx_status_t;

    // One complete result transaction.
    typedef struct packed {
        tx_status_t tx;
        rx_status_t rx;
    } result_t;

    // Builds a 10-bit frame, sent LSB first: start 0, data, stop 1.
    function automatic logic [9:0] make_frame(input logic [7:0] data);
        make_frame = {1'b1, data, 1'b0};
    endfunction

endpackage

`default_nettype wire

// ===== rtl/uart_8n1_bit_tick_transceiver.sv =====
// UART 8N1 transceiver, one event per input transaction.
// Input channel (in_valid / in_stall): mode selects a bit tick, a receive
// line falling edge, a transmit byte to queue, or a receiver arm with a
// byte count. rx_level is the receive line sampled at a tick.
// Output channel (out_valid / out_stall): exactly one result transaction
// per input transaction, in order, giving the transmit line level, the
// transmitter and holding register status, event pulses and any received
// byte, all as they stand after that event.
// Each result is registered into the output register, or into the skid register while the output holds a result.
// Throughput is one transaction per cycle while out_stall is low; the state
// update is a single registered step per event.
// When out_stall is held, a further input is still taken into a skid
// register; in_stall rises only once both output and skid hold results.
// Reset puts the line idle high, empties the holding register, disarms the
// receiver and clears the frame error; no result is pending afterwards.
`default_nettype none

module uart_8n1_bit_tick_transceiver (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  mode,
    input  wire logic        rx_level,
    input  wire logic [7:0]  tx_byte,
    input  wire logic [15:0] rx_count,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic             tx_line,
    output logic             tx_busy,
    output logic             hold_full,
    output logic             tx_rejected,
    output logic             tx_done,
    output logic [7:0]       rx_byte,
    output logic             rx_valid,
    output logic             rx_done,
    output logic             stop_error,
    output logic             rx_busy
);
    import utrx_pkg::*;

    logic       accept;
    logic       full;
    tx_status_t tx_status;
    rx_status_t rx_status;
    result_t    result;
    result_t    out_data;

    assign in_stall = full;
    assign accept   = in_valid && !full;

    // Transmitter.
    utrx_tx u_tx (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .mode    (mode),
        .tx_byte (tx_byte),
        .status  (tx_status)
    );

    // Receiver.
    utrx_rx u_rx (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .mode     (mode),
        .rx_level (rx_level),
        .rx_count (rx_count),
        .status   (rx_status)
    );

    assign result = {tx_status, rx_status};

    // Result register and skid stage.
    utrx_out u_out (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (accept),
        .result (result),
        .full   (full),
        .valid  (out_valid),
        .stall  (out_stall),
        .data   (out_data)
    );

    assign tx_line     = out_data.tx.line;
    assign tx_busy     = out_data.tx.busy;
    assign hold_full   = out_data.tx.hold_full;
    assign tx_rejected = out_data.tx.rejected;
    assign tx_done     = out_data.tx.done;
    assign rx_byte     = out_data.rx.byte_data;
    assign rx_valid    = out_data.rx.byte_valid;
    assign rx_done     = out_data.rx.done;
    assign stop_error  = out_data.rx.stop_error;
    assign rx_busy     = out_data.rx.busy;

endmodule

`default_nettype wire

// ===== rtl/utrx_tx.sv =====
`default_nettype none

module utrx_tx (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               accept,
    input  wire logic [1:0]         mode,
    input  wire logic [7:0]         tx_byte,
    output utrx_pkg::tx_status_t    status
);
    import utrx_pkg::*;

    logic       active_reg, active_next;
    logic [9:0] frame_reg, frame_next;
    logic [3:0] bit_count_reg, bit_count_next;
    logic       level_reg, level_next;
    logic [7:0] hold_byte_reg, hold_byte_next;
    logic       hold_valid_reg, hold_valid_next;
    logic       rejected;
    logic       done;
    logic [3:0] count_inc;

    assign count_inc = bit_count_reg + 4'd1;

    // Next transmitter state for the event in this transaction.
    always_comb
    begin
        active_next     = active_reg;
        frame_next      = frame_reg;
        bit_count_next  = bit_count_reg;
        level_next      = level_reg;
        hold_byte_next  = hold_byte_reg;
        hold_valid_next = hold_valid_reg;
        rejected        = 1'b0;
        done            = 1'b0;
        case (mode_t'(mode))
            MODE_TICK:
            begin
                if (active_reg)
                begin
                    level_next     = frame_reg[0];
                    frame_next     = {1'b0, frame_reg[9:1]};
                    bit_count_next = count_inc;
                    if (count_inc >= FRAME_BITS)
                    begin
                        if (hold_valid_reg)
                        begin
                            hold_valid_next = 1'b0;
                            frame_next      = make_frame(hold_byte_reg);
                            bit_count_next  = 4'd0;
                            active_next     = 1'b1;
                        end
                        else
                        begin
                            active_next = 1'b0;
                            done        = 1'b1;
                        end
                    end
                end
            end
            MODE_QUEUE:
            begin
                if (!active_reg)
                begin
                    frame_next     = make_frame(tx_byte);
                    bit_count_next = 4'd0;
                    active_next    = 1'b1;
                end
                else if (!hold_valid_reg)
                begin
                    hold_byte_next  = tx_byte;
                    hold_valid_next = 1'b1;
                end
                else
                begin
                    rejected = 1'b1;
                end
            end
            default:
            begin
                // Receive events leave the transmitter untouched.
            end
        endcase
    end

    // State registers advance only on an accepted transaction.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg     <= 1'b0;
            frame_reg      <= '1;
            bit_count_reg  <= 4'd0;
            level_reg      <= 1'b1;
            hold_byte_reg  <= 8'd0;
            hold_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            active_reg     <= active_next;
            frame_reg      <= frame_next;
            bit_count_reg  <= bit_count_next;
            level_reg      <= level_next;
            hold_byte_reg  <= hold_byte_next;
            hold_valid_reg <= hold_valid_next;
        end
    end

    // Status reflects the state after this transaction.
    always_comb
    begin
        status.line      = level_next;
        status.busy      = active_next;
        status.hold_full = hold_valid_next;
        status.rejected  = rejected;
        status.done      = done;
    end

endmodule

`default_nettype wire

// ===== rtl/utrx_rx.sv =====
`default_nettype none

module utrx_rx (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               accept,
    input  wire logic [1:0]         mode,
    input  wire logic               rx_level,
    input  wire logic [15:0]        rx_count,
    output utrx_pkg::rx_status_t    status
);
    import utrx_pkg::*;

    logic                   active_reg, active_next;
    logic [7:0]             data_reg, data_next;
    logic [3:0]             bit_count_reg, bit_count_next;
    logic [COUNT_WIDTH-1:0] remaining_reg, remaining_next;
    logic                   error_reg, error_next;
    logic [7:0]             got;
    logic                   valid;
    logic                   done;

    // Next receiver state for the event in this transaction.
    always_comb
    begin
        active_next    = active_reg;
        data_next      = data_reg;
        bit_count_next = bit_count_reg;
        remaining_next = remaining_reg;
        error_next     = error_reg;
        got            = 8'd0;
        valid          = 1'b0;
        done           = 1'b0;
        case (mode_t'(mode))
            MODE_TICK:
            begin
                if (active_reg)
                begin
                    if (bit_count_reg < DATA_BITS)
                    begin
                        data_next[bit_count_reg[2:0]] =
                            data_reg[bit_count_reg[2:0]] | rx_level;
                        bit_count_next = bit_count_reg + 4'd1;
                    end
                    else
                    begin
                        // Stop bit: report the byte and check framing.
                        if (!rx_level)
                        begin
                            error_next = 1'b1;
                        end
                        got   = data_reg;
                        valid = 1'b1;
                        if (remaining_reg != '0)
                        begin
                            remaining_next = remaining_reg - COUNT_WIDTH'(1);
                        end
                        done           = (remaining_next == '0);
                        active_next    = 1'b0;
                        bit_count_next = 4'd0;
                        data_next      = 8'd0;
                    end
                end
            end
            MODE_EDGE:
            begin
                if (!active_reg && remaining_reg != '0)
                begin
                    active_next    = 1'b1;
                    bit_count_next = 4'd0;
                    data_next      = 8'd0;
                end
            end
            MODE_ARM:
            begin
                remaining_next = COUNT_WIDTH'(rx_count);
                error_next     = 1'b0;
                active_next    = 1'b0;
                bit_count_next = 4'd0;
                data_next      = 8'd0;
            end
            default:
            begin
                // Queued transmit bytes leave the receiver untouched.
            end
        endcase
    end

    // State registers advance only on an accepted transaction.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            data_reg      <= 8'd0;
            bit_count_reg <= 4'd0;
            remaining_reg <= '0;
            error_reg     <= 1'b0;
        end
        else if (accept)
        begin
            active_reg    <= active_next;
            data_reg      <= data_next;
            bit_count_reg <= bit_count_next;
            remaining_reg <= remaining_next;
            error_reg     <= error_next;
        end
    end

    // Status reflects the state after this transaction.
    always_comb
    begin
        status.byte_data  = got;
        status.byte_valid = valid;
        status.done       = done;
        status.stop_error = error_next;
        status.busy       = active_next;
    end

endmodule

`default_nettype wire

// ===== rtl/utrx_out.sv =====
`default_nettype none

module utrx_out (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  wire utrx_pkg::result_t  result,
    output logic                    full,
    output logic                    valid,
    input  wire logic               stall,
    output utrx_pkg::result_t       data
);
    import utrx_pkg::*;

    result_t data_reg;
    result_t skid_reg;
    logic    valid_reg;
    logic    skid_valid_reg;
    logic    pop;

    assign pop   = valid_reg && !stall;
    assign full  = skid_valid_reg;
    assign valid = valid_reg;
    assign data  = data_reg;

    // Output register with a skid stage behind it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg      <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (pop)
        begin
            if (skid_valid_reg)
            begin
                skid_valid_reg <= 1'b0;
            end
            else if (!push)
            begin
                valid_reg <= 1'b0;
            end
        end
        else if (push)
        begin
            if (!valid_reg)
            begin
                valid_reg <= 1'b1;
            end
            else
            begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    // Payload moves without reset.
    always_ff @(posedge clk)
    begin
        if (pop && skid_valid_reg)
        begin
            data_reg <= skid_reg;
        end
        else if (push && (pop || !valid_reg))
        begin
            data_reg <= result;
        end
        if (push && valid_reg && !pop)
        begin
            skid_reg <= result;
        end
    end

endmodule

`default_nettype wire
